/* design/slpd_pkg.sv */
// shared constants, codes and word types of the 3x3 strict local peak detector
package slpd_pkg;

    // field widths and grid size
    localparam int COL_BITS    = 8;
    localparam int ROW_BITS    = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int WIDTH_BITS  = 9;
    localparam int TOTAL_BITS  = 16;
    localparam int MAX_WIDTH   = 2 ** COL_BITS;

    // task queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // operation codes of an input word
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [ROW_BITS-1:0]   ROW_MAX     = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = '1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // one line store entry: the two rows above the incoming one
    typedef struct packed {
        t_sample older;
        t_sample newer;
    } t_line_pair;

    // up to two decisions made by one input word
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                has_a;
        logic                has_b;
        logic                peak_a;
        logic                peak_b;
        logic                frame_end;
    } t_task;

    // one result word
    typedef struct packed {
        logic [ROW_BITS-1:0]   row_index;
        logic [COL_BITS-1:0]   col_index;
        logic                  is_peak;
        logic [TOTAL_BITS-1:0] peak_total;
        logic                  last_of_item;
        logic                  frame_done;
    } t_result;

endpackage

/* design/slpd_front.sv */
// front end: raster counters, line store, 3x3 window and peak comparisons
module slpd_front
    import slpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WIDTH_BITS-1:0] i_cfg_wdata,
    input  logic                  i_push,
    input  logic                  i_operation,
    input  t_sample               i_sample,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_q_push,
    output t_task                 o_q_task
);

    logic [WIDTH_BITS-1:0] r_row_width;
    logic [COL_BITS-1:0]   r_col, n_col;
    logic [ROW_BITS-1:0]   r_row, n_row;
    logic                  r_flush_row, n_flush_row;

    t_sample    r_wa [3];
    t_sample    r_wb [3];
    t_sample    col_r [3];

    t_line_pair r_line_mem [MAX_WIDTH];
    t_line_pair r_rd;
    t_line_pair wr_data;
    logic       wr_en;

    logic                  accept, ignore, advance, eff_flush, last;
    logic                  top_ok, bottom_ok, left_a, left_b, emit_a, emit_b;
    logic                  peak_a, peak_b;
    logic [WIDTH_BITS-1:0] width_eff, col_next;

    // input handshake and row classification
    assign accept    = i_push && !i_q_full;
    assign o_full    = i_q_full;
    assign eff_flush = (r_col == '0) ? (i_operation == OP_FLUSH) : r_flush_row;
    assign ignore    = (r_col == '0) && (i_operation == OP_FLUSH) && (r_row == '0);
    assign advance   = accept && !ignore;

    // row end against the effective width
    assign width_eff = ((r_row_width == '0) || (r_row_width > WIDTH_RESET)) ?
                       WIDTH_RESET : r_row_width;
    assign col_next  = {1'b0, r_col} + WIDTH_BITS'(1);
    assign last      = col_next >= width_eff;

    // incoming window column
    assign col_r[0] = r_rd.older;
    assign col_r[1] = r_rd.newer;
    assign col_r[2] = eff_flush ? '0 : i_sample;

    // neighbour availability at grid borders
    assign top_ok    = r_row >= ROW_BITS'(2);
    assign bottom_ok = !eff_flush;
    assign left_a    = r_col >= COL_BITS'(2);
    assign left_b    = r_col != '0;
    assign emit_a    = (r_row != '0) && (r_col != '0);
    assign emit_b    = (r_row != '0) && last;

    // strict comparisons for the middle and right window centres
    always_comb begin
        logic row_ok;
        peak_a = 1'b1;
        peak_b = 1'b1;
        row_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            row_ok = (i == 0) ? top_ok : ((i == 2) ? bottom_ok : 1'b1);
            if (left_a && row_ok && (r_wb[1] <= r_wa[i])) peak_a = 1'b0;
            if ((i != 1) && row_ok && (r_wb[1] <= r_wb[i])) peak_a = 1'b0;
            if (row_ok && (r_wb[1] <= col_r[i])) peak_a = 1'b0;
            if (left_b && row_ok && (col_r[1] <= r_wb[i])) peak_b = 1'b0;
            if ((i != 1) && row_ok && (col_r[1] <= col_r[i])) peak_b = 1'b0;
        end
    end

    // next raster position
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_flush_row = r_flush_row;
        if (advance) begin
            if (last) begin
                n_col       = '0;
                n_flush_row = 1'b0;
                if (eff_flush) begin
                    n_row = '0;
                end else if (r_row != ROW_MAX) begin
                    n_row = r_row + ROW_BITS'(1);
                end
            end else begin
                n_col       = r_col + COL_BITS'(1);
                n_flush_row = eff_flush;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= WIDTH_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_flush_row <= 1'b0;
        end else begin
            if (i_cfg_we) r_row_width <= i_cfg_wdata;
            r_col       <= n_col;
            r_row       <= n_row;
            r_flush_row <= n_flush_row;
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                r_wa[i] <= r_wb[i];
                r_wb[i] <= col_r[i];
            end
        end
    end

    // line store: write the current column, prefetch the next one
    assign wr_en   = advance && !eff_flush;
    assign wr_data = '{older: r_rd.newer, newer: i_sample};

    always_ff @(posedge i_clk) begin
        if (wr_en) r_line_mem[r_col] <= wr_data;
        if (wr_en && (n_col == r_col)) begin
            r_rd <= wr_data;
        end else begin
            r_rd <= r_line_mem[n_col];
        end
    end

    // task word to the back end
    assign o_q_push           = advance && (emit_a || emit_b);
    assign o_q_task.row       = r_row - ROW_BITS'(1);
    assign o_q_task.col       = r_col;
    assign o_q_task.has_a     = emit_a;
    assign o_q_task.has_b     = emit_b;
    assign o_q_task.peak_a    = peak_a;
    assign o_q_task.peak_b    = peak_b;
    assign o_q_task.frame_end = last && eff_flush;

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full)
        else $error("task pushed into a full queue");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && last && eff_flush) |=> (r_row == '0) && (r_col == '0) && !r_flush_row)
        else $error("raster position not cleared after frame end");
`endif

endmodule

/* design/slpd_task_queue.sv */
// short task queue between the front and back ends
module slpd_task_queue
    import slpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_task,
    output logic  o_empty
);

    t_task                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic                 do_push, do_pop;

    // status and head word
    assign o_full  = r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_task  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_task;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + QPTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_BITS + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_BITS + 1)'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
        else $error("task queue count beyond depth");
`endif

endmodule

/* design/slpd_back.sv */
// back end: splits tasks into result words, keeps the peak count, output register
module slpd_back
    import slpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_task                 i_q_task,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [ROW_BITS-1:0]   o_row_index,
    output logic [COL_BITS-1:0]   o_col_index,
    output logic                  o_is_peak,
    output logic [TOTAL_BITS-1:0] o_peak_total,
    output logic                  o_last_of_item,
    output logic                  o_frame_done
);

    logic                  r_half;
    logic                  r_out_valid;
    t_result               r_out;
    logic [TOTAL_BITS-1:0] r_peaks;

    logic                  load, first_of_two, take_a, sel_peak;
    logic [TOTAL_BITS-1:0] total;
    t_result               res;

    // pick the next decision from the head task
    assign load         = !i_q_empty && (!r_out_valid || i_pop);
    assign first_of_two = i_q_task.has_a && i_q_task.has_b && !r_half;
    assign take_a       = first_of_two || !i_q_task.has_b;
    assign sel_peak     = take_a ? i_q_task.peak_a : i_q_task.peak_b;

    // saturating peak count
    assign total = (sel_peak && (r_peaks != TOTAL_MAX)) ? r_peaks + TOTAL_BITS'(1) : r_peaks;

    // result word
    assign res.row_index    = i_q_task.row;
    assign res.col_index    = take_a ? i_q_task.col - COL_BITS'(1) : i_q_task.col;
    assign res.is_peak      = sel_peak;
    assign res.peak_total   = total;
    assign res.last_of_item = !first_of_two;
    assign res.frame_done   = !first_of_two && i_q_task.frame_end;

    assign o_q_pop = load && !first_of_two;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
            r_peaks     <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_half      <= first_of_two;
                r_peaks     <= res.frame_done ? '0 : total;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) r_out <= res;
    end

    assign o_empty        = !r_out_valid;
    assign o_row_index    = r_out.row_index;
    assign o_col_index    = r_out.col_index;
    assign o_is_peak      = r_out.is_peak;
    assign o_peak_total   = r_out.peak_total;
    assign o_last_of_item = r_out.last_of_item;
    assign o_frame_done   = r_out.frame_done;

`ifndef SYNTHESIS
    a_half_holds_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (!i_q_empty && i_q_task.has_a && i_q_task.has_b))
        else $error("second decision pending without a paired task at the head");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |-> r_out.last_of_item)
        else $error("frame end on a word that is not last of its item");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && res.frame_done) |=> (r_peaks == '0))
        else $error("peak count not cleared after frame end");
`endif

endmodule

/* design/strict_local_peak_detector_3x3.sv */
// top level of the 3x3 strict local peak detector
//
// Input queue side: a word (operation, sample) is taken on a clock edge with
// push high and full low. Samples arrive in raster order, row_width per row;
// a row that starts with a flush word ends the frame and decides the last row.
// Result queue side: while empty is low the oldest result sits on the o_
// ports and is taken on an edge with pop high. Each word gives zero, one or
// two results, the last one flagged by last_of_item; frame_done marks the
// final result of a frame. Decisions run one row behind the input.
// With nothing waiting ahead, the results of a taken word pass through the
// task queue and the output register. Throughput: one word per cycle while
// full is low. Each row but the first of a frame gives w results for w words:
// none for its first and two for its last when w is above one; the task queue
// evens this out against the one-result-per-cycle output register (pop high).
// Reset clears the raster position, row kind, peak count and width (256); the
// line store is not cleared and needs no clearing pass.
// When pop is held low the output register holds, the four-entry task queue
// fills, and full rises to stall the sender. The user writes row_width through
// i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
module strict_local_peak_detector_3x3
    import slpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WIDTH_BITS-1:0] i_cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_operation,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                  pop,
    output logic                  empty,
    output logic [ROW_BITS-1:0]   o_row_index,
    output logic [COL_BITS-1:0]   o_col_index,
    output logic                  o_is_peak,
    output logic [TOTAL_BITS-1:0] o_peak_total,
    output logic                  o_last_of_item,
    output logic                  o_frame_done
);

    logic  q_push, q_full, q_pop, q_empty;
    t_task q_in, q_out;

    // front end
    slpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_operation (i_operation),
        .i_sample    (t_sample'(i_sample)),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_task    (q_in)
    );

    // task queue
    slpd_task_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_task  (q_out),
        .o_empty (q_empty)
    );

    // back end
    slpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_task       (q_out),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_is_peak      (o_is_peak),
        .o_peak_total   (o_peak_total),
        .o_last_of_item (o_last_of_item),
        .o_frame_done   (o_frame_done)
    );

endmodule

/* tb/sv/testbench.sv */
// testbench of the 3x3 strict local peak detector: predictor, stimulus and result checks
module testbench;
    import slpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 16;
    localparam int MISMATCH_SHOWN   = 10;

    // receiver pacing modes
    typedef enum int {
        POP_FREE,
        POP_MOSTLY,
        POP_HALF,
        POP_HOLD
    } t_pop_pace;

    // block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [WIDTH_BITS-1:0] i_cfg_wdata = '0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  i_operation = OP_SAMPLE;
    t_sample               i_sample    = '0;
    logic                  pop         = 1'b0;
    logic                  empty;
    logic [ROW_BITS-1:0]   o_row_index;
    logic [COL_BITS-1:0]   o_col_index;
    logic                  o_is_peak;
    logic [TOTAL_BITS-1:0] o_peak_total;
    logic                  o_last_of_item;
    logic                  o_frame_done;

    // predictor state
    logic [WIDTH_BITS-1:0] width_reg = WIDTH_RESET;
    t_sample               older_row [MAX_WIDTH] = '{default: '0};
    t_sample               newer_row [MAX_WIDTH] = '{default: '0};
    t_sample               win [3][3] = '{default: '{default: '0}};
    int unsigned           col_pos    = 0;
    int unsigned           row_pos    = 0;
    int unsigned           peak_count = 0;
    bit                    in_flush_row = 1'b0;
    t_result               pending_decisions [$];

    // pacing and bookkeeping
    int          burst_left    = 8;
    int          pop_run       = 0;
    t_pop_pace   pop_pace      = POP_FREE;
    int          quiet_cycles  = 0;
    int unsigned words_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned peaks_seen    = 0;
    int unsigned frames_closed = 0;
    int unsigned mismatches    = 0;

    strict_local_peak_detector_3x3 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_sample       (i_sample),
        .pop            (pop),
        .empty          (empty),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_is_peak      (o_is_peak),
        .o_peak_total   (o_peak_total),
        .o_last_of_item (o_last_of_item),
        .o_frame_done   (o_frame_done)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // decide the window centre in column k of the middle window row
    function automatic t_result judge_centre(input int unsigned col, input int k,
                                             input bit left_ok, input bit right_ok,
                                             input bit top_ok, input bit bottom_ok);
        t_sample centre;
        bit      peak;
        t_result r;
        centre = win[1][k];
        peak   = 1'b1;
        for (int j = k - 1; j <= k + 1; j++) begin
            if (j > 2) continue;
            if (j < k && !left_ok) continue;
            if (j > k && !right_ok) continue;
            for (int i = 0; i < 3; i++) begin
                if (i == 1 && j == k) continue;
                if (i == 0 && !top_ok) continue;
                if (i == 2 && !bottom_ok) continue;
                if (centre <= win[i][j]) peak = 1'b0;
            end
        end
        if (peak && peak_count < TOTAL_MAX) peak_count++;
        r.row_index    = ROW_BITS'(row_pos - 1);
        r.col_index    = COL_BITS'(col);
        r.is_peak      = peak;
        r.peak_total   = TOTAL_BITS'(peak_count);
        r.last_of_item = 1'b0;
        r.frame_done   = 1'b0;
        return r;
    endfunction

    // work out the decisions caused by one accepted word
    task automatic predict_decisions(input logic op, input t_sample smp);
        int unsigned w;
        int unsigned c;
        bit          row_end;
        bit          top_ok;
        bit          bottom_ok;
        t_result     made [$];
        w = width_reg;
        if (w == 0 || w > MAX_WIDTH) w = MAX_WIDTH;
        c = col_pos;
        if (c >= MAX_WIDTH) c = 0;
        // the first word of a row fixes the row kind; a flush on an empty frame is dropped
        if (c == 0) begin
            if (op == OP_FLUSH && row_pos == 0) return;
            in_flush_row = (op == OP_FLUSH);
        end
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = older_row[c];
        win[1][2] = newer_row[c];
        win[2][2] = in_flush_row ? t_sample'(0) : smp;
        if (!in_flush_row) begin
            older_row[c] = newer_row[c];
            newer_row[c] = smp;
        end
        row_end   = (c + 1 >= w);
        top_ok    = (row_pos >= 2);
        bottom_ok = !in_flush_row;
        if (row_pos >= 1) begin
            if (c >= 1) begin
                made.push_back(judge_centre(c - 1, 1, c >= 2, 1'b1, top_ok, bottom_ok));
            end
            if (row_end) begin
                made.push_back(judge_centre(c, 2, c >= 1, 1'b0, top_ok, bottom_ok));
            end
        end
        // raster position, frame close
        if (row_end) begin
            col_pos = 0;
            if (in_flush_row) begin
                if (made.size() > 0) made[made.size() - 1].frame_done = 1'b1;
                row_pos      = 0;
                peak_count   = 0;
                in_flush_row = 1'b0;
            end else if (row_pos < 255) begin
                row_pos++;
            end
        end else begin
            col_pos = c + 1;
        end
        if (made.size() > 0) made[made.size() - 1].last_of_item = 1'b1;
        foreach (made[i]) pending_decisions.push_back(made[i]);
    endtask

    // offer one word, wait for it to be taken, then maybe leave a gap
    task automatic send_word(input logic op, input t_sample smp);
        int unsigned gap;
        push        <= 1'b1;
        i_operation <= op;
        i_sample    <= smp;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_decisions(op, smp);
        words_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // width write once every decision is out and the block has settled
    task automatic write_width(input logic [WIDTH_BITS-1:0] value);
        push <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        width_reg = value;
    endtask

    // sample values: plateaus, full range, or extremes mixed with small values
    function automatic t_sample random_sample(input int unsigned style);
        int v;
        case (style)
            0: begin
                v = $urandom_range(0, 4);
                return t_sample'(v - 2);
            end
            1: return t_sample'($urandom());
            default: begin
                v = $urandom_range(0, 2);
                if (v == 0) return 16'sh7FFF;
                if (v == 1) return 16'sh8000;
                v = $urandom_range(0, 200);
                return t_sample'(v - 100);
            end
        endcase
    endfunction

    // empty frame, one-sample grid, one column of equal values
    task automatic test_empty_and_single();
        write_width(WIDTH_BITS'(1));
        send_word(OP_FLUSH, 16'sh1234);
        send_word(OP_SAMPLE, 16'sh7FFF);
        send_word(OP_FLUSH, 16'sh0000);
        send_word(OP_SAMPLE, 16'sh8000);
        send_word(OP_SAMPLE, 16'sh8000);
        send_word(OP_FLUSH, 16'sh7FFF);
    endtask

    // 3x3 grid of extreme values with row kind bits mixed on later words
    task automatic test_extreme_grid();
        t_sample grid [9] = '{16'sh7FFF, 16'sh8000, 16'sh0001,
                              16'sh8000, 16'sh7FFF, 16'sh7FFF,
                              16'sh0000, 16'shFFFF, 16'sh5555};
        logic    ops [9]  = '{OP_SAMPLE, OP_FLUSH, OP_FLUSH,
                              OP_SAMPLE, OP_FLUSH, OP_SAMPLE,
                              OP_SAMPLE, OP_FLUSH, OP_FLUSH};
        write_width(WIDTH_BITS'(3));
        for (int i = 0; i < 9; i++) send_word(ops[i], grid[i]);
        send_word(OP_FLUSH, 16'sh0000);
        send_word(OP_SAMPLE, 16'sh8000);
        send_word(OP_FLUSH, 16'sh7FFF);
    endtask

    // narrower width written part way through a row ends that row early
    task automatic test_narrow_mid_row();
        write_width(WIDTH_BITS'(4));
        for (int i = 0; i < 6; i++) send_word(OP_SAMPLE, random_sample(2));
        write_width(WIDTH_BITS'(2));
        send_word(OP_FLUSH, random_sample(1));
        send_word(OP_FLUSH, 16'sh0000);
        send_word(OP_SAMPLE, 16'sh7FFF);
    endtask

    // random frames, mostly small, some with a dropped leading flush
    task automatic test_random_frames(input int unsigned target);
        int unsigned first_word;
        int unsigned w;
        int unsigned rows;
        int unsigned style;
        first_word = words_sent;
        while (words_sent - first_word < target) begin
            w     = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
            rows  = $urandom_range(1, 8);
            style = $urandom_range(0, 2);
            write_width(WIDTH_BITS'(w));
            if ($urandom_range(0, 5) == 0) send_word(OP_FLUSH, random_sample(1));
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < w; c++) begin
                    send_word((c == 0 || $urandom_range(0, 1) == 0) ? OP_SAMPLE : OP_FLUSH,
                              random_sample(style));
                end
            end
            for (int c = 0; c < w; c++) begin
                send_word((c == 0 || $urandom_range(0, 1) == 0) ? OP_FLUSH : OP_SAMPLE,
                          random_sample(1));
            end
        end
    endtask

    // full-width frame, width given as zero, all ones and the largest legal value
    task automatic test_wide_frame();
        write_width('0);
        for (int c = 0; c < MAX_WIDTH; c++) send_word(OP_SAMPLE, random_sample(1));
        write_width('1);
        for (int c = 0; c < MAX_WIDTH; c++) send_word(OP_SAMPLE, random_sample(0));
        write_width(WIDTH_RESET);
        for (int c = 0; c < MAX_WIDTH; c++) begin
            send_word((c == 0 || $urandom_range(0, 1) == 0) ? OP_FLUSH : OP_SAMPLE,
                      random_sample(1));
        end
    endtask

    // more rows than the row count can hold
    task automatic test_tall_frame();
        write_width(WIDTH_BITS'(1));
        for (int r = 0; r < 260; r++) send_word(OP_SAMPLE, random_sample(0));
        send_word(OP_FLUSH, random_sample(1));
    endtask

    // receiver pacing
    always @(posedge i_clk) begin
        if (pop_run <= 0) begin
            pop_pace = t_pop_pace'($urandom_range(0, 3));
            pop_run  = (pop_pace == POP_HOLD) ? $urandom_range(1, 24)
                                              : $urandom_range(1, 60);
        end
        pop_run--;
        case (pop_pace)
            POP_FREE:   pop <= 1'b1;
            POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
            POP_HALF:   pop <= ($urandom_range(0, 1) == 1);
            default:    pop <= 1'b0;
        endcase
    end

    // compare each taken result word with the oldest predicted decision
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got = {o_row_index, o_col_index, o_is_peak, o_peak_total,
                   o_last_of_item, o_frame_done};
            results_seen++;
            if (got.is_peak) peaks_seen++;
            if (got.frame_done) frames_closed++;
            if (pending_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN) begin
                    $display("%t unexpected result: row %0d col %0d peak %0b %s",
                             $realtime, got.row_index, got.col_index, got.is_peak,
                             $sformatf("total %0d last %0b done %0b", got.peak_total,
                                       got.last_of_item, got.frame_done));
                end
            end else begin
                want = pending_decisions.pop_front();
                if (got.row_index !== want.row_index || got.col_index !== want.col_index ||
                    got.is_peak !== want.is_peak || got.peak_total !== want.peak_total ||
                    got.last_of_item !== want.last_of_item ||
                    got.frame_done !== want.frame_done) begin
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOWN) begin
                        $display("%t mismatch: expected row %0d col %0d peak %0b %s",
                                 $realtime, want.row_index, want.col_index, want.is_peak,
                                 $sformatf("total %0d last %0b done %0b", want.peak_total,
                                           want.last_of_item, want.frame_done));
                        $display("%t           actual   row %0d col %0d peak %0b %s",
                                 $realtime, got.row_index, got.col_index, got.is_peak,
                                 $sformatf("total %0d last %0b done %0b", got.peak_total,
                                           got.last_of_item, got.frame_done));
                    end
                end
            end
        end
    end

    // cycles in which no word moved on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%t no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_single();
        test_extreme_grid();
        test_narrow_mid_row();
        test_random_frames(370);
        test_wide_frame();
        test_tall_frame();
        push <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d words sent, %0d results checked (%0d peaks, %0d frames closed), %s",
                 words_sent, results_seen, peaks_seen, frames_closed,
                 $sformatf("%0d mismatches", mismatches));
        $display("widths 1 to 256 and out-of-range codes, narrowing mid-row, held row count");
        if (mismatches == 0 && pending_decisions.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/slpd_pkg.sv
design/slpd_front.sv
design/slpd_task_queue.sv
design/slpd_back.sv
design/strict_local_peak_detector_3x3.sv
tb/sv/testbench.sv
